@@ src/wspe_pkg.sv @@
// ----------------------------------------------------------------------------
// wspe_pkg
// Shared types and constants for the single-wire LED pulse encoder.
// ----------------------------------------------------------------------------
package wspe_pkg;

	localparam int unsigned WORD_BITS = 24;
	localparam int unsigned BIT_IDX_W = 5;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned PULSE_W   = 8;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;

	// Register reset values
	localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 8'd2;
	localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 8'd7;
	localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 8'd6;
	localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 8'd3;
	localparam logic [TICK_W-1:0]  PRE_LOW_RST   = 16'd0;

	// Register index (paddr[4:2])
	typedef enum logic [2:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_PRE_LOW   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_PRELOW = 4'b0010,
		PH_HIGH   = 4'b0100,
		PH_LOW    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0]  pre_low;
		logic [PULSE_W-1:0] one_low;
		logic [PULSE_W-1:0] one_high;
		logic [PULSE_W-1:0] zero_low;
		logic [PULSE_W-1:0] zero_high;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       blue;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [PIX_W-1:0] pixel_count;
		logic             action;
	} item_t;

	typedef struct packed {
		logic start_rejected;
		logic frame_done;
		logic busy_res;
		logic line_level;
	} res_t;

endpackage

@@ src/wspe_regs.sv @@
// ----------------------------------------------------------------------------
// wspe_regs
// APB register file holding the pulse widths and the pre-low time.
// ----------------------------------------------------------------------------
module wspe_regs
	import wspe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= ZERO_HIGH_RST;
			cfg_q.zero_low  <= ZERO_LOW_RST;
			cfg_q.one_high  <= ONE_HIGH_RST;
			cfg_q.one_low   <= ONE_LOW_RST;
			cfg_q.pre_low   <= PRE_LOW_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ZERO_HIGH: cfg_q.zero_high <= pwdata[PULSE_W-1:0];
				REG_ZERO_LOW:  cfg_q.zero_low  <= pwdata[PULSE_W-1:0];
				REG_ONE_HIGH:  cfg_q.one_high  <= pwdata[PULSE_W-1:0];
				REG_ONE_LOW:   cfg_q.one_low   <= pwdata[PULSE_W-1:0];
				REG_PRE_LOW:   cfg_q.pre_low   <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ZERO_HIGH: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.zero_high};
			REG_ZERO_LOW:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.zero_low};
			REG_ONE_HIGH:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.one_high};
			REG_ONE_LOW:   prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.one_low};
			REG_PRE_LOW:   prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_q.pre_low};
			default:       prdata = '0;
		endcase
	end

endmodule

@@ src/wspe_engine.sv @@
// ----------------------------------------------------------------------------
// wspe_engine
// Frame state machine: advances one tick per request and registers the result.
// ----------------------------------------------------------------------------
module wspe_engine
	import wspe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_take,
	output logic  res_valid,
	output res_t  res,
	input  logic  res_ready
);

	phase_t                 phase_q;
	logic [TICK_W-1:0]      tick_q;
	logic [BIT_IDX_W-1:0]   bit_q;
	logic [PIX_W-1:0]       pix_q;
	logic [WORD_BITS-1:0]   word_q;
	logic                   res_valid_q;
	res_t                   res_q;

	phase_t                 ph_n;
	logic [TICK_W-1:0]      tick_n;
	logic [BIT_IDX_W-1:0]   bit_n;
	logic [PIX_W-1:0]       pix_n;
	logic [WORD_BITS-1:0]   word_n;
	res_t                   res_n;

	assign item_take = item_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		logic                 cur;
		logic [TICK_W-1:0]    len;
		logic [TICK_W-1:0]    tick_inc;
		logic [BIT_IDX_W-1:0] bit_inc;
		logic [PIX_W-1:0]     pix_dec;

		ph_n   = phase_q;
		tick_n = tick_q;
		bit_n  = bit_q;
		pix_n  = pix_q;
		word_n = word_q;
		res_n  = '0;

		if (item.action && phase_q != PH_IDLE) begin
			res_n.start_rejected = 1'b1;
		end else if (item.action) begin
			pix_n  = item.pixel_count;
			word_n = {item.green, item.red, item.blue};
			bit_n  = '0;
			tick_n = '0;
			if (cfg.pre_low != '0) begin
				ph_n = PH_PRELOW;
			end else if (item.pixel_count != '0) begin
				ph_n = PH_HIGH;
			end else begin
				res_n.frame_done = 1'b1;
			end
		end

		// bit index never passes the word end, but an out-of-range index sends zero
		cur = (bit_n < BIT_IDX_W'(WORD_BITS)) ?
			word_n[BIT_IDX_W'(WORD_BITS - 1) - bit_n] : 1'b0;

		case (ph_n)
			PH_PRELOW: len = cfg.pre_low;
			PH_HIGH:   len = {{(TICK_W-PULSE_W){1'b0}}, cur ? cfg.one_high : cfg.zero_high};
			default:   len = {{(TICK_W-PULSE_W){1'b0}}, cur ? cfg.one_low : cfg.zero_low};
		endcase

		tick_inc = tick_n + 1'b1;
		bit_inc  = bit_n + 1'b1;
		pix_dec  = pix_n - 1'b1;

		if (ph_n != PH_IDLE) begin
			res_n.busy_res   = 1'b1;
			res_n.line_level = (ph_n == PH_HIGH);
			tick_n           = tick_inc;
			if (tick_inc >= len) begin
				tick_n = '0;
				case (ph_n)
					PH_PRELOW: begin
						bit_n = '0;
						if (pix_n != '0) begin
							ph_n = PH_HIGH;
						end else begin
							ph_n             = PH_IDLE;
							res_n.frame_done = 1'b1;
						end
					end
					PH_HIGH: begin
						ph_n = PH_LOW;
					end
					default: begin
						if (bit_inc >= BIT_IDX_W'(WORD_BITS)) begin
							bit_n = '0;
							pix_n = pix_dec;
							if (pix_dec == '0) begin
								ph_n             = PH_IDLE;
								res_n.frame_done = 1'b1;
							end else begin
								ph_n = PH_HIGH;
							end
						end else begin
							bit_n = bit_inc;
							ph_n  = PH_HIGH;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			pix_q       <= '0;
			word_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				phase_q <= ph_n;
				tick_q  <= tick_n;
				bit_q   <= bit_n;
				pix_q   <= pix_n;
				word_q  <= word_n;
			end
			if (item_take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_q <= res_n;
		end
	end

endmodule

@@ src/ws2812_pulse_encoder_top.sv @@
// ----------------------------------------------------------------------------
// ws2812_pulse_encoder_top
// Single-wire LED line encoder, one output level per input tick.
// ----------------------------------------------------------------------------
// Each request on the input stream is one tick of the line waveform and gives
// exactly one result. One request is taken per clock cycle when the output
// side is ready; each request passes the input register, then the frame state
// update into the result register, before its result shows up.
// Throughput is set by the state update of the frame engine, which stalls only while its result waits.
// A start (tuser high) while a frame runs is dropped and flagged, and counts
// as an ordinary tick of that frame. tlast marks the tick that ends a frame.
module ws2812_pulse_encoder_top
	import wspe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // pixel_count, green, red, blue
	input  logic              s_axis_tuser,  // action (1 = start frame)
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // line_level, busy_res, start_rejected, 0 pad
	output logic              m_axis_tlast,  // frame_done
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  item_take;
	logic  res_valid;
	res_t  res;

	wspe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_axis_tready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.action      <= s_axis_tuser;
			item_s1.pixel_count <= s_axis_tdata[7:0];
			item_s1.green       <= s_axis_tdata[15:8];
			item_s1.red         <= s_axis_tdata[23:16];
			item_s1.blue        <= s_axis_tdata[31:24];
		end
	end

	wspe_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item       (item_s1),
		.item_take  (item_take),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (m_axis_tready)
	);

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {5'b0, res.start_rejected, res.busy_res, res.line_level};
	assign m_axis_tlast  = res.frame_done;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick requests into the single-wire LED pulse encoder and checks the
// line level, busy, frame-done and rejected-start flags of every result
// against a tick-by-tick line predictor. The register port sets pulse
// widths and pre-low time between phases of the run; both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import wspe_pkg::*;

	localparam int HOLD_CYCLES = 90;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;   // pixel_count, green, red, blue
	logic              s_axis_tuser;   // action (1 = start frame)
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;   // line_level, busy_res, start_rejected, 0 pad
	logic              m_axis_tlast;   // frame_done
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// line predictor state
	cfg_t              line_cfg;
	phase_t            ln_phase;
	logic [TICK_W-1:0] tick_cnt;
	logic [4:0]        bit_pos;
	logic [7:0]        pix_left;
	logic [23:0]       grb_word;

	res_t              expected_ticks[$];
	int unsigned       mismatch_cnt;
	bit                src_idle_en;
	bit                sink_idle_en;
	bit                hold_req;

	ws2812_pulse_encoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// One tick of the line: returns what the block must report for it.
	function automatic res_t predict_line_tick(item_t it);
		res_t              r;
		logic [TICK_W-1:0] len;
		logic              cur;
		r = '0;
		if (it.action && ln_phase != PH_IDLE) begin
			r.start_rejected = 1'b1;
		end else if (it.action) begin
			pix_left = it.pixel_count;
			grb_word = {it.green, it.red, it.blue};
			bit_pos  = '0;
			tick_cnt = '0;
			if (line_cfg.pre_low != '0)
				ln_phase = PH_PRELOW;
			else if (pix_left != '0)
				ln_phase = PH_HIGH;
			else
				r.frame_done = 1'b1;  // empty frame takes no tick
		end
		if (ln_phase != PH_IDLE) begin
			r.busy_res   = 1'b1;
			r.line_level = (ln_phase == PH_HIGH);
			cur = (bit_pos < WORD_BITS) ? grb_word[23 - int'(bit_pos)] : 1'b0;
			case (ln_phase)
				PH_PRELOW: len = line_cfg.pre_low;
				PH_HIGH:   len = {8'd0, cur ? line_cfg.one_high : line_cfg.zero_high};
				default:   len = {8'd0, cur ? line_cfg.one_low : line_cfg.zero_low};
			endcase
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= len) begin
				tick_cnt = '0;
				case (ln_phase)
					PH_PRELOW: begin
						bit_pos = '0;
						if (pix_left != '0) begin
							ln_phase = PH_HIGH;
						end else begin
							ln_phase     = PH_IDLE;
							r.frame_done = 1'b1;
						end
					end
					PH_HIGH: ln_phase = PH_LOW;
					default: begin
						bit_pos = bit_pos + 1'b1;
						if (bit_pos >= WORD_BITS) begin
							bit_pos  = '0;
							pix_left = pix_left - 1'b1;
							if (pix_left == '0) begin
								ln_phase     = PH_IDLE;
								r.frame_done = 1'b1;
							end else begin
								ln_phase = PH_HIGH;
							end
						end else begin
							ln_phase = PH_HIGH;
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	function automatic item_t idle_item();
		return item_t'({$urandom(), 1'b0});
	endfunction

	function automatic item_t start_item(logic [7:0] pix, logic [7:0] g, logic [7:0] r,
			logic [7:0] b);
		item_t it;
		it             = '0;
		it.action      = 1'b1;
		it.pixel_count = pix;
		it.green       = g;
		it.red         = r;
		it.blue        = b;
		return it;
	endfunction

	function automatic void log_mismatch(string what, logic [7:0] want, logic [7:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
	endfunction

	// Called right after a falling edge; returns right after a falling edge.
	task automatic send_tick(item_t it);
		if (src_idle_en && $urandom_range(99) < 10) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.blue, it.red, it.green, it.pixel_count};
		s_axis_tuser  <= it.action;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_ticks.push_back(predict_line_tick(it));
		@(negedge clk);
	endtask

	task automatic run_idle(int n);
		repeat (n) send_tick(idle_item());
	endtask

	task automatic run_to_end();
		while (ln_phase != PH_IDLE)
			send_tick(idle_item());
	endtask

	// Lets every request in flight come out, then a short pause for the pipeline.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ZERO_HIGH: line_cfg.zero_high = val[7:0];
			REG_ZERO_LOW:  line_cfg.zero_low  = val[7:0];
			REG_ONE_HIGH:  line_cfg.one_high  = val[7:0];
			REG_ONE_LOW:   line_cfg.one_low   = val[7:0];
			REG_PRE_LOW:   line_cfg.pre_low   = val;
			default: ;
		endcase
	endtask

	task automatic set_widths(logic [7:0] zh, logic [7:0] zl, logic [7:0] oh,
			logic [7:0] ol, logic [15:0] pre);
		drain();
		reg_write(REG_ZERO_HIGH, {8'd0, zh});
		reg_write(REG_ZERO_LOW, {8'd0, zl});
		reg_write(REG_ONE_HIGH, {8'd0, oh});
		reg_write(REG_ONE_LOW, {8'd0, ol});
		reg_write(REG_PRE_LOW, pre);
	endtask

	task automatic test_default_timing();
		run_idle(4);
		send_tick(start_item(8'd1, 8'hFF, 8'h00, 8'hA5));
		run_idle(20);
		send_tick('1);  // start while busy, every field bit set
		run_to_end();
		run_idle(3);
	endtask

	task automatic test_short_frames();
		set_widths(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
		send_tick(start_item(8'd0, 8'h12, 8'h34, 8'h56));  // empty frame
		send_tick(start_item(8'd0, 8'h00, 8'h00, 8'h00));
		send_tick(start_item(8'd2, 8'h5A, 8'hC3, 8'h0F));  // one tick per phase
		run_to_end();
		set_widths(8'd0, 8'd0, 8'd0, 8'd0, 16'd1);
		send_tick(start_item(8'd0, 8'hFF, 8'hFF, 8'hFF));  // pre-low only
		run_idle(2);
		set_widths(8'd1, 8'd2, 8'd2, 8'd1, 16'd5);
		send_tick(start_item(8'd0, 8'h00, 8'h00, 8'h00));
		run_to_end();
		send_tick(start_item(8'd1, 8'hAA, 8'h55, 8'hF0));
		run_to_end();
	endtask

	// Widest high pulse on the single zero bit of the word.
	task automatic test_width_extremes();
		set_widths(8'd255, 8'd1, 8'd1, 8'd1, 16'd0);
		send_tick(start_item(8'd1, 8'hFF, 8'hFF, 8'hFE));
		run_to_end();
	endtask

	// Widths changed while a frame is in progress take effect on the phase under way.
	task automatic test_cfg_midframe();
		set_widths(8'd2, 8'd2, 8'd2, 8'd2, 16'd6);
		send_tick(start_item(8'd1, 8'($urandom), 8'($urandom), 8'($urandom)));
		run_idle(3);
		drain();
		reg_write(REG_PRE_LOW, 16'd2);
		run_idle(10);
		drain();
		reg_write(REG_ZERO_HIGH, 16'd1);
		reg_write(REG_ONE_HIGH, 16'd1);
		run_to_end();
	endtask

	task automatic test_output_stall();
		set_widths(8'd1, 8'd2, 8'd2, 8'd1, 16'd3);
		send_tick(start_item(8'd1, 8'h0F, 8'hF0, 8'h3C));
		hold_req = 1'b1;
		run_idle(100);
		run_to_end();
	endtask

	task automatic random_phase(int n);
		item_t it;
		set_widths(8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
			8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
			16'($urandom_range(0, 12)));
		repeat (n) begin
			it = idle_item();
			if (ln_phase == PH_IDLE) begin
				if ($urandom_range(99) < 30) begin
					it.action = 1'b1;
					it.pixel_count = ($urandom_range(9) == 0) ? 8'($urandom_range(3, 5))
						: 8'($urandom_range(0, 2));
				end
			end else if ($urandom_range(99) < 4) begin
				it.action = 1'b1;  // rejected, fields arbitrary
			end
			send_tick(it);
		end
	endtask

	task automatic test_no_gaps();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		random_phase(180);
		drain();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	task automatic test_random_frames();
		repeat (3) random_phase(80);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_axis_tready <= !(sink_idle_en && arst_n && $urandom_range(99) < 14)
					&& arst_n;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_ticks.size() == 0) begin
				log_mismatch("unexpected result", 8'd0, m_axis_tdata);
			end else begin
				want = expected_ticks.pop_front();
				if (m_axis_tdata[0] !== want.line_level)
					log_mismatch("line_level", 8'(want.line_level), 8'(m_axis_tdata[0]));
				if (m_axis_tdata[1] !== want.busy_res)
					log_mismatch("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[1]));
				if (m_axis_tdata[2] !== want.start_rejected)
					log_mismatch("start_rejected", 8'(want.start_rejected),
						8'(m_axis_tdata[2]));
				if (m_axis_tlast !== want.frame_done)
					log_mismatch("frame_done", 8'(want.frame_done), 8'(m_axis_tlast));
				if (m_axis_tdata[7:3] !== 5'd0)
					log_mismatch("tdata pad", 8'd0, {3'd0, m_axis_tdata[7:3]});
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		mismatch_cnt  = 0;
		src_idle_en   = 1'b1;
		sink_idle_en  = 1'b1;
		hold_req      = 1'b0;
		line_cfg.zero_high = ZERO_HIGH_RST;
		line_cfg.zero_low  = ZERO_LOW_RST;
		line_cfg.one_high  = ONE_HIGH_RST;
		line_cfg.one_low   = ONE_LOW_RST;
		line_cfg.pre_low   = PRE_LOW_RST;
		ln_phase = PH_IDLE;
		tick_cnt = '0;
		bit_pos  = '0;
		pix_left = '0;
		grb_word = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_timing();
		test_short_frames();
		test_width_extremes();
		test_cfg_midframe();
		test_output_stall();
		test_no_gaps();
		test_random_frames();
		drain();

		if (mismatch_cnt == 0 && expected_ticks.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ ws2812_pulse_encoder_top.f @@
src/wspe_pkg.sv
src/wspe_regs.sv
src/wspe_engine.sv
src/ws2812_pulse_encoder_top.sv
tb/testbench.sv
